@@ sv/bvp_pkg.sv @@
// Package for the battery voltage to percent unit.
// Holds the discharge curve, per-segment constants and shared types.
// No dependencies; bvp_seg, bvp_scale and the top level import it.
package bvp_pkg;

  // Field and datapath widths.
  localparam int MvW        = 13;
  localparam int PctW       = 7;
  localparam int SegW       = 4;
  localparam int OffsetW    = 9;
  localparam int DeltaW     = 4;
  localparam int SpanW      = 9;
  localparam int RecipW     = 12;
  localparam int RecipShift = 16;
  localparam int ProdW      = 11;
  localparam int QuotW      = 4;

  localparam int CurvePoints = 13;
  localparam int SegCount    = CurvePoints - 1;

  typedef logic [MvW-1:0]     mv_t;
  typedef logic [PctW-1:0]    pct_t;
  typedef logic [SegW-1:0]    seg_t;
  typedef logic [OffsetW-1:0] offset_t;
  typedef logic [DeltaW-1:0]  delta_t;
  typedef logic [SpanW-1:0]   span_t;
  typedef logic [RecipW-1:0]  recip_t;
  typedef logic [ProdW-1:0]   prod_t;
  typedef logic [QuotW-1:0]   quot_t;

  // Clamp code: inside the curve, above the top point or below the bottom point.
  typedef enum logic [1:0] {
    ClampNone = 2'd0,
    ClampHigh = 2'd1,
    ClampLow  = 2'd2
  } clamp_e;

  // Breakpoints from the top of the curve down, in millivolts.
  localparam mv_t CurveMv [CurvePoints] = '{
    13'd4200, 13'd4150, 13'd4110, 13'd4080, 13'd4020, 13'd3980, 13'd3950,
    13'd3910, 13'd3870, 13'd3830, 13'd3790, 13'd3700, 13'd3300
  };

  localparam pct_t PctFull  = 7'd100;
  localparam pct_t PctEmpty = 7'd0;

  // Segment k runs from breakpoint k+1 (low end) up to breakpoint k.
  localparam mv_t SegMvLo [SegCount] = '{
    13'd4150, 13'd4110, 13'd4080, 13'd4020, 13'd3980, 13'd3950,
    13'd3910, 13'd3870, 13'd3830, 13'd3790, 13'd3700, 13'd3300
  };

  localparam pct_t SegPctLo [SegCount] = '{
    7'd95, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd5, 7'd0
  };

  // Percent rise across each segment.
  localparam delta_t SegDelta [SegCount] = '{
    4'd5, 4'd5, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd5, 4'd5
  };

  // Voltage width of each segment in millivolts.
  localparam span_t SegSpan [SegCount] = '{
    9'd50, 9'd40, 9'd30, 9'd60, 9'd40, 9'd30, 9'd40, 9'd40, 9'd40, 9'd40, 9'd90, 9'd400
  };

  // floor(2^RecipShift / span). With products below 2^RecipShift the
  // quotient estimate is exact or one low.
  localparam recip_t SegRecip [SegCount] = '{
    12'd1310, 12'd1638, 12'd2184, 12'd1092, 12'd1638, 12'd2184,
    12'd1638, 12'd1638, 12'd1638, 12'd1638, 12'd728, 12'd163
  };

  // What the segment stages hand to the scaling stages.
  typedef struct packed {
    clamp_e  clamp;
    seg_t    seg;
    offset_t offset;
  } seg_data_t;

endpackage

@@ sv/bvp_if.sv @@
// Stream interfaces of the battery voltage to percent unit.
// Valid/ready channels for the voltage input and the percent result.
// Depends on nothing; the top level takes them as ports and its users instantiate them.
interface bvp_volt_if #(
  parameter int VOLTAGE_BITS = 13
);
  logic                    valid;
  logic                    ready;
  logic [VOLTAGE_BITS-1:0] voltage_mv;

  modport source (output valid, output voltage_mv, input ready);
  modport sink   (input valid, input voltage_mv, output ready);
endinterface

interface bvp_pct_if;
  logic       valid;
  logic       ready;
  logic [6:0] percent;

  modport source (output valid, output percent, input ready);
  modport sink   (input valid, input percent, output ready);
endinterface

@@ sv/bvp_seg.sv @@
// Segment stages: find the curve segment of a voltage, then its offset.
// Two registered stages with per-stage valid bits and stall propagation.
// Depends on bvp_pkg.
module bvp_seg #(
  parameter int VoltageBits = 13
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VoltageBits-1:0] voltage_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output bvp_pkg::seg_data_t     out_o
);
  import bvp_pkg::*;

  logic                   s1_valid_q;
  logic [VoltageBits-1:0] s1_v_q;
  seg_t                   s1_seg_q, s1_seg_d;
  clamp_e                 s1_clamp_q, s1_clamp_d;
  logic                   s2_valid_q;
  seg_data_t              s2_q, s2_d;
  logic                   en1, en2;
  logic [VoltageBits-1:0] diff;

  // A stage takes a new transfer when it is empty or its content moves on.
  assign en2        = !s2_valid_q || out_ready_i;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;

  // Stage 1: clamp checks and segment index, counting inner breakpoints above v.
  // The bottom point is left out so the index stays on the last segment.
  always_comb begin
    if (voltage_i >= VoltageBits'(CurveMv[0])) begin
      s1_clamp_d = ClampHigh;
    end else if (voltage_i <= VoltageBits'(CurveMv[CurvePoints-1])) begin
      s1_clamp_d = ClampLow;
    end else begin
      s1_clamp_d = ClampNone;
    end
    s1_seg_d = '0;
    for (int j = 1; j < SegCount; j++) begin
      if (VoltageBits'(CurveMv[j]) > voltage_i) begin
        s1_seg_d = s1_seg_d + seg_t'(1);
      end
    end
  end

  // Stage 2: distance above the low end of the segment.
  always_comb begin
    diff         = s1_v_q - VoltageBits'(SegMvLo[s1_seg_q]);
    s2_d.clamp  = s1_clamp_q;
    s2_d.seg    = s1_seg_q;
    s2_d.offset = diff[OffsetW-1:0];
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_q <= in_valid_i;
      end
      if (en2) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_v_q     <= voltage_i;
      s1_seg_q   <= s1_seg_d;
      s1_clamp_q <= s1_clamp_d;
    end
    if (en2 && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_o       = s2_q;

endmodule

@@ sv/bvp_scale.sv @@
// Scaling stages: offset times percent rise, divide by the segment span.
// Three registered stages: multiply, reciprocal multiply, correct and add.
// Depends on bvp_pkg.
module bvp_scale (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bvp_pkg::seg_data_t in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bvp_pkg::pct_t      percent_o
);
  import bvp_pkg::*;

  typedef struct packed {
    clamp_e clamp;
    seg_t   seg;
    prod_t  prod;
  } prod_data_t;

  typedef struct packed {
    clamp_e clamp;
    seg_t   seg;
    prod_t  prod;
    quot_t  quot;
  } quot_data_t;

  logic                            s3_valid_q, s4_valid_q, s5_valid_q;
  prod_data_t                      s3_q, s3_d;
  quot_data_t                      s4_q, s4_d;
  pct_t                            s5_q, s5_d;
  logic                            en3, en4, en5;
  logic [OffsetW+DeltaW-1:0]       prod_full;
  logic [ProdW+RecipW-1:0]         recip_full;
  logic [QuotW+SpanW-1:0]          quot_span;
  logic [QuotW+SpanW-1:0]          rem;
  quot_t                           quot_fix;

  assign en5        = !s5_valid_q || out_ready_i;
  assign en4        = !s4_valid_q || en5;
  assign en3        = !s3_valid_q || en4;
  assign in_ready_o = en3;

  // Stage 3: product of the offset and the segment's percent rise.
  always_comb begin
    prod_full  = (OffsetW+DeltaW)'(in_i.offset) * (OffsetW+DeltaW)'(SegDelta[in_i.seg]);
    s3_d.clamp = in_i.clamp;
    s3_d.seg   = in_i.seg;
    s3_d.prod  = prod_full[ProdW-1:0];
  end

  // Stage 4: quotient estimate from the reciprocal of the span.
  always_comb begin
    recip_full = (ProdW+RecipW)'(s3_q.prod) * (ProdW+RecipW)'(SegRecip[s3_q.seg]);
    s4_d.clamp = s3_q.clamp;
    s4_d.seg   = s3_q.seg;
    s4_d.prod  = s3_q.prod;
    s4_d.quot  = recip_full[RecipShift +: QuotW];
  end

  // Stage 5: raise the estimate by one where the remainder reaches the span,
  // then add the segment base or apply the clamp.
  always_comb begin
    quot_span = (QuotW+SpanW)'(s4_q.quot) * (QuotW+SpanW)'(SegSpan[s4_q.seg]);
    rem       = (QuotW+SpanW)'(s4_q.prod) - quot_span;
    quot_fix  = s4_q.quot;
    if (rem >= (QuotW+SpanW)'(SegSpan[s4_q.seg])) begin
      quot_fix = s4_q.quot + quot_t'(1);
    end
    case (s4_q.clamp)
      ClampHigh: s5_d = PctFull;
      ClampLow:  s5_d = PctEmpty;
      ClampNone: s5_d = SegPctLo[s4_q.seg] + pct_t'(quot_fix);
      default:   s5_d = PctEmpty;
    endcase
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (en3) begin
        s3_valid_q <= in_valid_i;
      end
      if (en4) begin
        s4_valid_q <= s3_valid_q;
      end
      if (en5) begin
        s5_valid_q <= s4_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en3 && in_valid_i) begin
      s3_q <= s3_d;
    end
    if (en4 && s3_valid_q) begin
      s4_q <= s4_d;
    end
    if (en5 && s4_valid_q) begin
      s5_q <= s5_d;
    end
  end

  assign out_valid_o = s5_valid_q;
  assign percent_o   = s5_q;

endmodule

@@ sv/battery_voltage_to_percent_unit.sv @@
// Channel   Dir  Payload                       Transfer when
// volt_i    in   voltage_mv [VOLTAGE_BITS-1:0]  valid && ready
// pct_o     out  percent [6:0]                  valid && ready
//
// Five register stages: segment select, offset, multiply, reciprocal
// multiply, correct and add. One transfer per cycle in and out while the
// output is not held; an item passes through the stages in that order.
// Reset clears only the valid bits; the pipeline then takes items at once.
// Each stage holds its item while the next stage is full and stalled, and
// accepts a new one whenever it is empty, so bubbles close up under a stall.
// Top level of the battery voltage to percent unit.
// Depends on bvp_pkg, bvp_if, bvp_seg and bvp_scale.
module battery_voltage_to_percent_unit #(
  parameter int VOLTAGE_BITS = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bvp_volt_if.sink      volt_i,
  bvp_pct_if.source     pct_o
);
  import bvp_pkg::*;

  logic      seg_valid;
  logic      seg_ready;
  seg_data_t seg_data;

  // Segment select and offset.
  bvp_seg #(
    .VoltageBits(VOLTAGE_BITS)
  ) u_seg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (volt_i.valid),
    .in_ready_o (volt_i.ready),
    .voltage_i  (volt_i.voltage_mv),
    .out_valid_o(seg_valid),
    .out_ready_i(seg_ready),
    .out_o      (seg_data)
  );

  // Interpolation within the segment.
  bvp_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (seg_valid),
    .in_ready_o (seg_ready),
    .in_i       (seg_data),
    .out_valid_o(pct_o.valid),
    .out_ready_i(pct_o.ready),
    .percent_o  (pct_o.percent)
  );

endmodule

@@ sv/bvp_checker.sv @@
// Port checker for the battery voltage to percent unit, and its bind.
// Watches the voltage and percent channels only.
// Depends on battery_voltage_to_percent_unit and bvp_if.
module bvp_port_checker #(
  parameter int VoltageBits = 13
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic [VoltageBits-1:0] voltage_mv_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [6:0]             percent_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // A result that is held back stays the same until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(percent_i))
    else $error("held result changed or dropped");

  // A percentage never exceeds full charge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> percent_i <= 7'd100)
    else $error("percent above 100");

  // With the output ready throughout, an accepted item shows up at the output after passing the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
    |=> out_valid_i)
    else $error("result missing after pipeline latency");

  // A voltage at or above the top breakpoint reads as full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && voltage_mv_i >= VoltageBits'(4200) ##1 out_ready_i ##1 out_ready_i
    ##1 out_ready_i ##1 out_ready_i |=> percent_i == 7'd100)
    else $error("full-scale voltage not reported as 100 percent");

endmodule

bind battery_voltage_to_percent_unit bvp_port_checker #(
  .VoltageBits(VOLTAGE_BITS)
) u_bvp_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (volt_i.valid),
  .in_ready_i  (volt_i.ready),
  .voltage_mv_i(volt_i.voltage_mv),
  .out_valid_i (pct_o.valid),
  .out_ready_i (pct_o.ready),
  .percent_i   (pct_o.percent)
);
